/* rtl/trial_division_prime_test_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the trial division prime test unit
// Clocked concurrent checks with an asynchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_UNIT_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_UNIT_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define TDPT_ASSERT_SAME(lbl, clk_sig, rst_n_sig, ante, cons, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) \
		(ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TDPT_ASSERT_NEXT(lbl, clk_sig, rst_n_sig, ante, cons, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) \
		(ante) |=> (cons)) else $error(msg);

`else

`define TDPT_ASSERT_SAME(lbl, clk_sig, rst_n_sig, ante, cons, msg)
`define TDPT_ASSERT_NEXT(lbl, clk_sig, rst_n_sig, ante, cons, msg)

`endif

`endif

/* rtl/tdpt_pkg.sv */
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared constants, FSM state type and control and status structs of the prime tester.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

	// Bits of the number that take part in the test (4..32).
	localparam int VALUE_WIDTH   = 16;
	// Fixed widths of the request and response fields.
	localparam int NUMBER_WIDTH  = 16;
	localparam int FACTOR_WIDTH  = 16;
	// Divisor squared can reach 2**VALUE_WIDTH before the loop ends.
	localparam int SQ_WIDTH      = VALUE_WIDTH + 2;
	localparam int CNT_WIDTH     = $clog2(VALUE_WIDTH + 1);
	localparam int FIRST_DIVISOR = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TEST,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                   start;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [VALUE_WIDTH-1:0] divisor;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

/* rtl/tdpt_req_if.sv */
// ----------------------------------------------------------------------------
// tdpt_req_if
// Request channel: one number to test per valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdpt_req_if;
	logic                             valid;
	logic                             ready;
	logic [tdpt_pkg::NUMBER_WIDTH-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface

`default_nettype wire

/* rtl/tdpt_rsp_if.sv */
// ----------------------------------------------------------------------------
// tdpt_rsp_if
// Response channel: primality flag and smallest factor per valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdpt_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             prime_flag;
	logic [tdpt_pkg::FACTOR_WIDTH-1:0] smallest_factor;

	modport source (output valid, output prime_flag, output smallest_factor, input ready);
	modport sink   (input valid, input prime_flag, input smallest_factor, output ready);
endinterface

`default_nettype wire

/* rtl/tdpt_divider.sv */
// ----------------------------------------------------------------------------
// tdpt_divider
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trial_division_prime_test_unit_macros.svh"

module tdpt_divider (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tdpt_pkg::div_ctrl_t               ctrl,
	output tdpt_pkg::div_stat_t                    stat,
	output logic [tdpt_pkg::VALUE_WIDTH-1:0]       remainder
);

	localparam int VW = tdpt_pkg::VALUE_WIDTH;
	localparam int CW = tdpt_pkg::CNT_WIDTH;

	logic [VW-1:0] shift_q;
	logic [VW-1:0] divisor_q;
	logic [VW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          fits;

	// Bring down the next dividend bit and subtract when the divisor fits.
	assign trial = {rem_q, shift_q[VW-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = (trial >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (ctrl.start) begin
				cnt_q <= CW'(VW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			shift_q   <= ctrl.dividend;
			divisor_q <= ctrl.divisor;
			rem_q     <= '0;
		end else if (cnt_q != '0) begin
			shift_q <= {shift_q[VW-2:0], 1'b0};
			rem_q   <= fits ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign remainder = rem_q;

	`TDPT_ASSERT_NEXT(a_start_loads_count, clk, arst_n, ctrl.start, cnt_q == CW'(VW),
		"divider count not loaded on start")
	`TDPT_ASSERT_SAME(a_done_when_drained, clk, arst_n, done_q, cnt_q == '0,
		"divider done while bits remain")
	`TDPT_ASSERT_NEXT(a_done_single_pulse, clk, arst_n, done_q && !ctrl.start, !done_q,
		"divider done held for more than one cycle")

endmodule

`default_nettype wire

/* rtl/trial_division_prime_test_unit.sv */
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit
// Trial-division primality test with a bit-serial remainder unit.
// ----------------------------------------------------------------------------
// Each request carries one number; its low VALUE_WIDTH bits are tested and
// exactly one response follows: prime_flag, and smallest_factor, the first
// divisor 2, 3, 4, ... that leaves no remainder (0 when the number is prime).
// Divisors are tried while divisor squared does not exceed the number; the
// square is kept exactly by adding 2d+1 per step, with no square root. Zero
// and one are reported as not prime. For each trial divisor the TEST state
// compares the square and starts the divider, the divider works through all
// VALUE_WIDTH dividend bits, and the DIVIDE state takes its result. One
// number is tested at a time; the request side is ready whenever the tester
// is idle, while the last response may still sit in the output register
// waiting for the sink.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trial_division_prime_test_unit_macros.svh"

module trial_division_prime_test_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tdpt_req_if.sink   req,
	tdpt_rsp_if.source rsp
);

	localparam int VW = tdpt_pkg::VALUE_WIDTH;
	localparam int SW = tdpt_pkg::SQ_WIDTH;
	localparam int FW = tdpt_pkg::FACTOR_WIDTH;

	tdpt_pkg::state_t    state_q;
	tdpt_pkg::state_t    state_d;
	tdpt_pkg::div_ctrl_t div_ctrl;
	tdpt_pkg::div_stat_t div_stat;

	logic [VW-1:0] number_q;     // held number
	logic [VW-1:0] divisor_q;    // current trial divisor
	logic [SW-1:0] square_q;     // divisor_q squared
	logic          prime_q;
	logic [FW-1:0] factor_q;
	logic [VW-1:0] remainder;

	logic          out_valid_q;
	logic          out_prime_q;
	logic [FW-1:0] out_factor_q;

	logic req_take;
	logic below_two;
	logic past_root;
	logic div_hit;
	logic load_out;

	assign req_take  = req.valid && req.ready;
	assign below_two = (number_q < VW'(tdpt_pkg::FIRST_DIVISOR));
	assign past_root = (square_q > SW'(number_q));
	assign div_hit   = (remainder == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tdpt_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = tdpt_pkg::ST_TEST;
				end
			end
			tdpt_pkg::ST_TEST: begin
				if (below_two || past_root) begin
					state_d = tdpt_pkg::ST_FINISH;
				end else begin
					state_d = tdpt_pkg::ST_DIVIDE;
				end
			end
			tdpt_pkg::ST_DIVIDE: begin
				if (div_stat.done) begin
					state_d = div_hit ? tdpt_pkg::ST_FINISH : tdpt_pkg::ST_TEST;
				end
			end
			tdpt_pkg::ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = tdpt_pkg::ST_IDLE;
				end
			end
			default: state_d = tdpt_pkg::ST_IDLE;
		endcase
	end

	// FSM outputs.
	always_comb begin
		req.ready         = 1'b0;
		load_out          = 1'b0;
		div_ctrl.start    = 1'b0;
		div_ctrl.dividend = number_q;
		div_ctrl.divisor  = divisor_q;
		case (state_q)
			tdpt_pkg::ST_IDLE:   req.ready      = 1'b1;
			tdpt_pkg::ST_TEST:   div_ctrl.start = !below_two && !past_root;
			tdpt_pkg::ST_DIVIDE: ;
			tdpt_pkg::ST_FINISH: load_out       = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tdpt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Trial loop datapath.
	always_ff @(posedge clk) begin
		if (req_take) begin
			number_q  <= VW'(req.number);
			divisor_q <= VW'(tdpt_pkg::FIRST_DIVISOR);
			square_q  <= SW'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
			prime_q   <= 1'b0;
			factor_q  <= '0;
		end else if (state_q == tdpt_pkg::ST_TEST) begin
			// Zero and one are not prime; no divisor up to the root means prime.
			if (below_two) begin
				prime_q <= 1'b0;
			end else if (past_root) begin
				prime_q <= 1'b1;
			end
		end else if (state_q == tdpt_pkg::ST_DIVIDE && div_stat.done) begin
			if (div_hit) begin
				prime_q  <= 1'b0;
				factor_q <= FW'(divisor_q);
			end else begin
				// (d+1)^2 = d^2 + 2d + 1
				square_q  <= square_q + SW'({divisor_q, 1'b1});
				divisor_q <= divisor_q + VW'(1);
			end
		end
	end

	// Output register: hold the response until the sink takes it.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_prime_q  <= prime_q;
			out_factor_q <= factor_q;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.prime_flag      = out_prime_q;
	assign rsp.smallest_factor = out_factor_q;

	tdpt_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (div_ctrl),
		.stat      (div_stat),
		.remainder (remainder)
	);

	`TDPT_ASSERT_NEXT(a_take_starts_test, clk, arst_n, req_take,
		state_q == tdpt_pkg::ST_TEST, "accepted request did not start a test")
	`TDPT_ASSERT_SAME(a_start_when_free, clk, arst_n, div_ctrl.start,
		!div_stat.busy, "divider restarted while busy")
	`TDPT_ASSERT_SAME(a_prime_no_factor, clk, arst_n, out_valid_q && out_prime_q,
		out_factor_q == '0, "prime response carries a factor")
	`TDPT_ASSERT_NEXT(a_load_sets_valid, clk, arst_n, load_out, out_valid_q,
		"finished response not presented")

endmodule

`default_nettype wire
